/* hw/rtl/rle_pkg.sv */
`timescale 1ns / 1ps

package rle_pkg;

	// packet job kinds
	localparam logic [1:0] JOB_NONE = 2'd0;
	localparam logic [1:0] JOB_RUN  = 2'd1;
	localparam logic [1:0] JOB_LIT  = 2'd2;

	// longest run packet
	localparam logic [7:0] MAX_RUN = 8'd128;

	// one packet waiting to go out
	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] cnt;      // literal bytes held in the store
		logic       tail_en;  // literal ends with the byte in tail
		logic [7:0] tail;
		logic [7:0] run_len;
		logic [7:0] run_val;
	} rle_job_t;

	// byte write into the literal store, pos is the byte place in the packet
	typedef struct packed {
		logic       en;
		logic [6:0] pos;
		logic [7:0] data;
	} rle_wr_t;

	// one formatted result
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            pkt_end;
	} rle_res_t;

	function automatic rle_job_t run_job(input logic [7:0] len, input logic [7:0] val);
		rle_job_t j;
		j         = '0;
		j.kind    = JOB_RUN;
		j.run_len = len;
		j.run_val = val;
		return j;
	endfunction

	function automatic rle_job_t lit_job(input logic [6:0] cnt, input logic tail_en,
			input logic [7:0] tail);
		rle_job_t j;
		j         = '0;
		j.kind    = JOB_LIT;
		j.cnt     = cnt;
		j.tail_en = tail_en;
		j.tail    = tail;
		return j;
	endfunction

endpackage

/* hw/rtl/rle_packet_encoder_top.sv */
`timescale 1ns / 1ps

// Run-length packet encoder for a byte stream.
// Input channel: in_valid / in_stall carry data_byte and stream_end, one byte
// per item; stream_end marks the final byte and flushes all pending data.
// Output channel: out_valid / out_stall carry results of up to four packet
// bytes (out_byte0..3, byte_count), packet_end on the last result of a packet
// and last_of_step on the last result caused by one input item.
// Pending literal bytes sit in a word-wide store with byte lanes, so a
// literal packet is read back one result per memory read.
// Timing: an item that closes no packet is taken without stalling. An item
// that produces results holds in_stall high while it is flushed: the READ
// state starts the store read, then per result the LOAD state takes the
// registered memory read and the WAIT state holds the output handshake. The
// first result becomes valid once READ and LOAD have passed.
// Reset clears all control state and output flags, not the output bytes or
// the literal store; neither holds anything that is read before it is written.
// While the receiver stalls, the current result holds and no input is taken.
module rle_packet_encoder_top #(
	parameter int MAX_LITERAL = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [2:0] byte_count,
	output logic       packet_end,
	output logic       last_of_step
);
	import rle_pkg::*;

	localparam int Words = MAX_LITERAL / 4 + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;

	// encoder state
	logic [6:0] lit_count_q, lit_count_d;
	logic [7:0] run_value_q, run_value_d;
	logic [7:0] run_len_q, run_len_d;
	logic [7:0] held_q, held_d;
	logic       held_valid_q, held_valid_d;
	logic       in_run_q, in_run_d;
	logic [6:0] cnt_inc;

	// flush sequencing
	rle_job_t   cur_q, pend_q;
	rle_job_t   job_a, job_b;
	logic [4:0] word_q;
	logic [4:0] rd_word;
	rle_wr_t    wr;
	logic [3:0][7:0] rd_data;
	rle_res_t   res;

	// output register
	logic [3:0][7:0] out_bytes_q;
	logic [2:0]      byte_count_q;
	logic            packet_end_q;
	logic            last_q;

	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid && (state_q == ST_IDLE);
	assign out_acc = (state_q == ST_WAIT) && !out_stall;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_WAIT);
	assign out_byte0    = out_bytes_q[0];
	assign out_byte1    = out_bytes_q[1];
	assign out_byte2    = out_bytes_q[2];
	assign out_byte3    = out_bytes_q[3];
	assign byte_count   = byte_count_q;
	assign packet_end   = packet_end_q;
	assign last_of_step = last_q;

	// classify the incoming byte and collect up to two packets
	always_comb begin
		lit_count_d  = lit_count_q;
		run_value_d  = run_value_q;
		run_len_d    = run_len_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		in_run_d     = in_run_q;
		job_a        = '0;
		job_b        = '0;
		wr           = '0;
		cnt_inc      = lit_count_q + 7'd1;

		if (in_run_q) begin
			if (data_byte == run_value_q && run_len_q < MAX_RUN) begin
				run_len_d = run_len_q + 8'd1;
			end else begin
				job_a        = run_job(run_len_q, run_value_q);
				in_run_d     = 1'b0;
				run_len_d    = 8'd0;
				held_d       = data_byte;
				held_valid_d = 1'b1;
			end
		end else if (!held_valid_q) begin
			held_d       = data_byte;
			held_valid_d = 1'b1;
		end else if (data_byte == held_q) begin
			if (lit_count_q != 7'd0) begin
				job_a = lit_job(lit_count_q, 1'b0, 8'd0);
			end
			lit_count_d  = 7'd0;
			in_run_d     = 1'b1;
			run_value_d  = data_byte;
			run_len_d    = 8'd2;
			held_valid_d = 1'b0;
		end else begin
			// header sits at byte 0, so literal byte i goes to place i+1
			wr.en       = 1'b1;
			wr.pos      = cnt_inc;
			wr.data     = held_q;
			held_d      = data_byte;
			lit_count_d = cnt_inc;
			if (cnt_inc >= 7'(MAX_LITERAL)) begin
				job_a       = lit_job(cnt_inc, 1'b0, 8'd0);
				lit_count_d = 7'd0;
			end
		end

		// end of stream: flush and start over
		if (stream_end) begin
			if (in_run_d) begin
				job_b = run_job(run_len_d, run_value_d);
			end else if (held_valid_d) begin
				job_b = lit_job(lit_count_d, 1'b1, held_d);
			end
			lit_count_d  = 7'd0;
			run_value_d  = 8'd0;
			run_len_d    = 8'd0;
			held_d       = 8'd0;
			held_valid_d = 1'b0;
			in_run_d     = 1'b0;
		end

		if (!in_acc) begin
			wr.en = 1'b0;
		end
	end

	// store read address
	always_comb begin
		rd_word = 5'd0;
		if (out_acc && !packet_end_q) begin
			rd_word = word_q + 5'd1;
		end
	end

	rle_lit_mem #(
		.Words(Words)
	) u_mem (
		.clk    (clk),
		.wr     (wr),
		.rd_word(rd_word),
		.rd_data(rd_data)
	);

	rle_fmt u_fmt (
		.job     (cur_q),
		.word    (word_q),
		.mem_data(rd_data),
		.res     (res)
	);

	// encoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_count_q  <= '0;
			run_value_q  <= '0;
			run_len_q    <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			in_run_q     <= 1'b0;
		end else if (in_acc) begin
			lit_count_q  <= lit_count_d;
			run_value_q  <= run_value_d;
			run_len_q    <= run_len_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			in_run_q     <= in_run_d;
		end
	end

	// flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			pend_q  <= '0;
			word_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					word_q <= 5'd0;
					if (in_acc) begin
						if (job_a.kind != JOB_NONE) begin
							cur_q   <= job_a;
							pend_q  <= job_b;
							state_q <= ST_READ;
						end else if (job_b.kind != JOB_NONE) begin
							cur_q   <= job_b;
							pend_q  <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_acc) begin
						if (!packet_end_q) begin
							word_q  <= word_q + 5'd1;
							state_q <= ST_LOAD;
						end else if (pend_q.kind != JOB_NONE) begin
							cur_q   <= pend_q;
							pend_q  <= '0;
							word_q  <= 5'd0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register loads one formatted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 3'd0;
			packet_end_q <= 1'b0;
			last_q       <= 1'b0;
		end else if (state_q == ST_LOAD) begin
			byte_count_q <= res.cnt;
			packet_end_q <= res.pkt_end;
			last_q       <= res.pkt_end && (pend_q.kind == JOB_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			out_bytes_q <= res.bytes;
		end
	end

endmodule

/* hw/rtl/rle_lit_mem.sv */
`timescale 1ns / 1ps

module rle_lit_mem #(
	parameter int Words = 32
) (
	input  logic               clk,
	input  rle_pkg::rle_wr_t   wr,
	input  logic [4:0]         rd_word,
	output logic [3:0][7:0]    rd_data
);
	import rle_pkg::*;

	localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;

	logic [3:0][7:0] mem [Words];
	logic [4:0]      wr_word;
	logic [1:0]      wr_lane;

	assign wr_word = wr.pos[6:2];
	assign wr_lane = wr.pos[1:0];

	// byte-lane write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_word[AddrW-1:0]][wr_lane] <= wr.data;
		end
	end

	// registered word read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_word[AddrW-1:0]];
	end

endmodule

/* hw/rtl/rle_fmt.sv */
`timescale 1ns / 1ps

module rle_fmt (
	input  rle_pkg::rle_job_t  job,
	input  logic [4:0]         word,
	input  logic [3:0][7:0]    mem_data,
	output rle_pkg::rle_res_t  res
);
	import rle_pkg::*;

	logic [7:0] total;
	logic [7:0] base;
	logic [7:0] remain;
	logic [7:0] hdr;
	logic [7:0] p;

	// build one four-byte slice of the packet
	always_comb begin
		if (job.kind == JOB_RUN) begin
			total = 8'd2;
			hdr   = job.run_len + 8'd127;
		end else begin
			total = {1'b0, job.cnt} + {7'd0, job.tail_en} + 8'd1;
			hdr   = {1'b0, job.cnt} + {7'd0, job.tail_en} - 8'd1;
		end
		base        = {1'b0, word, 2'b00};
		remain      = total - base;
		res         = '0;
		res.cnt     = (remain >= 8'd4) ? 3'd4 : remain[2:0];
		res.pkt_end = (remain <= 8'd4);
		p           = base;
		for (int l = 0; l < 4; l++) begin
			p = base + 8'(l);
			if (p < total) begin
				if (p == 8'd0) begin
					res.bytes[l] = hdr;
				end else if (job.kind == JOB_RUN) begin
					res.bytes[l] = job.run_val;
				end else if (job.tail_en && (p == total - 8'd1)) begin
					res.bytes[l] = job.tail;
				end else begin
					res.bytes[l] = mem_data[l];
				end
			end
		end
	end

endmodule

/* hw/rtl/rle_chk.sv */
`timescale 1ns / 1ps

module rle_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte0,
	input logic [2:0] byte_count,
	input logic       packet_end,
	input logic       last_of_step
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte0) && $stable(byte_count))
		else $error("stalled result changed");

	// no input taken while a result is shown
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// only the final slice of a packet may be short
	a_full_slice: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_end |-> byte_count == 3'd4)
		else $error("short slice inside a packet");

	// the last result of an item closes a packet
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_step |-> packet_end)
		else $error("item ended inside a packet");

	// byte count stays in range
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
		else $error("byte count out of range");

endmodule

bind rle_packet_encoder_top rle_chk u_rle_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte0   (out_byte0),
	.byte_count  (byte_count),
	.packet_end  (packet_end),
	.last_of_step(last_of_step)
);

/* sim/rle_packet_encoder_top_test.sv */
`timescale 1ns / 1ps

module rle_packet_encoder_top_test;

	localparam int LIT_MAX  = 127;
	localparam int RUN_MAX  = int'(rle_pkg::MAX_RUN);
	localparam int DRAIN_CY = 80;

	typedef logic [7:0] byte_q_t[$];

	// one output item as the encoder should produce it
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] cnt;
		logic       pend;
		logic       lstep;
	} enc_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       stream_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [2:0] byte_count;
	logic       packet_end;
	logic       last_of_step;

	// results still owed by the encoder, oldest first
	enc_result_t expected_results[$];
	int          err_cnt;
	int          step_cnt;
	int          item_cnt;
	bit          calm;
	int          hold_req;

	// encoder state as the predictor tracks it
	logic [7:0] lit_buf[128];
	int         lit_cnt;
	logic [7:0] run_val;
	int         run_len;
	logic [7:0] hold_byte;
	bit         hold_v;
	bit         run_on;

	rle_packet_encoder_top #(
		.MAX_LITERAL(LIT_MAX)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.stream_end  (stream_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte0   (out_byte0),
		.out_byte1   (out_byte1),
		.out_byte2   (out_byte2),
		.out_byte3   (out_byte3),
		.byte_count  (byte_count),
		.packet_end  (packet_end),
		.last_of_step(last_of_step)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("FAIL rle_packet_encoder_top");
		$finish;
	end

	// split a packet into items of up to four bytes
	function automatic void queue_packet(input byte_q_t pkt);
		int          pos;
		int          c;
		enc_result_t r;
		pos = 0;
		while (pos < pkt.size()) begin
			c = pkt.size() - pos;
			if (c > 4)
				c = 4;
			r     = '0;
			r.b0  = pkt[pos];
			if (c > 1)
				r.b1 = pkt[pos + 1];
			if (c > 2)
				r.b2 = pkt[pos + 2];
			if (c > 3)
				r.b3 = pkt[pos + 3];
			r.cnt = 3'(c);
			pos   = pos + c;
			r.pend = (pos >= pkt.size());
			expected_results.push_back(r);
			step_cnt++;
		end
	endfunction

	// literal packet: header count-1, then the held bytes
	function automatic void flush_literal();
		byte_q_t pkt;
		int      n;
		n = lit_cnt & 127;
		if (n == 0)
			return;
		pkt.push_back(8'(n - 1));
		for (int i = 0; i < n; i++)
			pkt.push_back(lit_buf[i]);
		queue_packet(pkt);
		lit_cnt = 0;
	endfunction

	// run packet: header 128+count-1, then the byte
	function automatic void flush_run();
		byte_q_t pkt;
		pkt.push_back(8'(128 + run_len - 1));
		pkt.push_back(run_val);
		queue_packet(pkt);
		run_on  = 1'b0;
		run_len = 0;
	endfunction

	// expected packets for one accepted input byte
	function automatic void encode_byte(input logic [7:0] b, input logic last);
		step_cnt = 0;
		if (run_on) begin
			if (b == run_val && run_len < RUN_MAX) begin
				run_len++;
			end else begin
				flush_run();
				hold_byte = b;
				hold_v    = 1'b1;
			end
		end else if (!hold_v) begin
			hold_byte = b;
			hold_v    = 1'b1;
		end else if (b == hold_byte) begin
			flush_literal();
			run_on  = 1'b1;
			run_val = b;
			run_len = 2;
			hold_v  = 1'b0;
		end else begin
			lit_buf[lit_cnt & 127] = hold_byte;
			lit_cnt++;
			hold_byte = b;
			if (lit_cnt >= LIT_MAX)
				flush_literal();
		end

		// end of stream sends everything and starts over
		if (last) begin
			if (run_on)
				flush_run();
			if (hold_v) begin
				if (lit_cnt >= LIT_MAX)
					flush_literal();
				lit_buf[lit_cnt & 127] = hold_byte;
				lit_cnt++;
				flush_literal();
			end
			lit_cnt   = 0;
			run_val   = '0;
			run_len   = 0;
			hold_byte = '0;
			hold_v    = 1'b0;
			run_on    = 1'b0;
		end

		if (step_cnt > 0)
			expected_results[expected_results.size() - 1].lstep = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// offer one item and wait until it is taken
	task automatic send_item(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		stream_end <= last;
		encode_byte(b, last);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		item_cnt++;
	endtask

	task automatic send_bytes(input byte_q_t s, input bit close);
		for (int i = 0; i < s.size(); i++)
			send_item(s[i], close && (i == s.size() - 1));
	endtask

	// byte that differs from its neighbor
	function automatic logic [7:0] other_byte(input logic [7:0] prev, input bit have_prev);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		while (have_prev && v == prev)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	// well-formed stream of runs and literals with random content
	task automatic send_random_stream(input int target, input bit allow_big);
		byte_q_t    s;
		logic [7:0] v;
		logic [7:0] prev;
		bit         have_prev;
		int         len;
		have_prev = 1'b0;
		prev      = '0;
		while (s.size() < target) begin
			if (allow_big && $urandom_range(19) == 0)
				len = $urandom_range(120, 135);
			else
				len = $urandom_range(1, 8);
			if ($urandom_range(1)) begin
				v = other_byte(prev, have_prev);
				repeat (len + 1)
					s.push_back(v);
				prev      = v;
				have_prev = 1'b1;
			end else begin
				repeat (len) begin
					v = other_byte(prev, have_prev);
					s.push_back(v);
					prev      = v;
					have_prev = 1'b1;
				end
			end
		end
		send_bytes(s, 1'b1);
	endtask

	// short literals and runs, extreme byte values, one-byte streams
	task automatic test_directed();
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'hAA, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b1);
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h34, 1'b1);
		send_item(8'h01, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h03, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b1);
	endtask

	// full run with overflow, full literal and the capped end-of-stream literal
	task automatic test_full_packets();
		byte_q_t    s;
		logic [7:0] v;
		calm = 1'b1;
		v    = 8'($urandom_range(255));
		repeat (RUN_MAX + 1)
			s.push_back(v);
		s.push_back(~v);
		send_bytes(s, 1'b1);
		calm = 1'b0;
		s = {};
		for (int i = 0; i < LIT_MAX + 1; i++)
			s.push_back(other_byte(i > 0 ? s[i - 1] : 8'h00, i > 0));
		send_bytes(s, 1'b1);
	endtask

	// receiver holds off while short packets keep coming
	task automatic test_backpressure();
		logic [7:0] v;
		hold_req = 400;
		repeat (10) begin
			v = 8'($urandom_range(255));
			send_item(v, 1'b0);
			send_item(v, 1'b0);
			send_item(~v, 1'b1);
		end
	endtask

	// mostly well-formed streams, some noise with stray stream ends
	task automatic test_random();
		int first;
		first = item_cnt;
		while (item_cnt - first < 40) begin
			if ($urandom_range(99) < 80) begin
				send_random_stream($urandom_range(4, 12), 1'b0);
			end else begin
				repeat (10) begin
					case ($urandom_range(3))
						0: send_item(8'h00, $urandom_range(9) == 0);
						1: send_item(8'hFF, $urandom_range(9) == 0);
						default: send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
					endcase
				end
			end
		end
		// close whatever the noise left open
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// receiver side: random stalls and the long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_stall <= 1'b1;
				hold_req  <= hold_req - 1;
			end else if (!calm) begin
				out_stall <= ($urandom_range(99) < 14);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each accepted item with the oldest expectation
	always @(posedge clk) begin : check_results
		enc_result_t got;
		enc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_byte0, out_byte1, out_byte2, out_byte3, byte_count, packet_end,
				last_of_step};
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected item", int'(got), 0);
			end else begin
				want = expected_results.pop_front();
				if (got.b0 != want.b0)
					report_mismatch("out_byte0", int'(got.b0), int'(want.b0));
				if (got.b1 != want.b1)
					report_mismatch("out_byte1", int'(got.b1), int'(want.b1));
				if (got.b2 != want.b2)
					report_mismatch("out_byte2", int'(got.b2), int'(want.b2));
				if (got.b3 != want.b3)
					report_mismatch("out_byte3", int'(got.b3), int'(want.b3));
				if (got.cnt != want.cnt)
					report_mismatch("byte_count", int'(got.cnt), int'(want.cnt));
				if (got.pend != want.pend)
					report_mismatch("packet_end", int'(got.pend), int'(want.pend));
				if (got.lstep != want.lstep)
					report_mismatch("last_of_step", int'(got.lstep), int'(want.lstep));
			end
		end
	end

	// reset, tests in turn, drain
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = '0;
		stream_end = 1'b0;
		err_cnt    = 0;
		item_cnt   = 0;
		calm       = 1'b0;
		hold_req   = 0;
		lit_cnt    = 0;
		run_val    = '0;
		run_len    = 0;
		hold_byte  = '0;
		hold_v     = 1'b0;
		run_on     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_packets();
		test_backpressure();
		test_random();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CY) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS rle_packet_encoder_top");
		else
			$display("FAIL rle_packet_encoder_top");
		$finish;
	end

endmodule

/* rle_packet_encoder_top.f */
hw/rtl/rle_pkg.sv
hw/rtl/rle_lit_mem.sv
hw/rtl/rle_fmt.sv
hw/rtl/rle_packet_encoder_top.sv
hw/rtl/rle_chk.sv
sim/rle_packet_encoder_top_test.sv
